// ===== rtl/sd_card_spi_responder_assert.svh =====
// Assertion macros for the SD card SPI responder.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef SD_CARD_SPI_RESPONDER_ASSERT_SVH
`define SD_CARD_SPI_RESPONDER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent
`define SDR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent
`define SDR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sdr_pkg.sv =====
// Shared types and constants for the SD card SPI responder.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package sdr_pkg;

	localparam int STORE_ADDR_BITS = 16;
	localparam int BLOCK_BYTES     = 512;
	localparam int WBUF_BYTES      = 514;

	// Frame bytes and response codes
	localparam logic [7:0] START_BIT   = 8'h40;
	localparam logic [7:0] START_CLR   = 8'hBF;
	localparam logic [7:0] DATA_TOKEN  = 8'hFE;
	localparam logic [7:0] RESP_OK     = 8'h00;
	localparam logic [7:0] RESP_IDLE   = 8'h01;
	localparam logic [7:0] RESP_APP    = 8'h02;
	localparam logic [7:0] RESP_WR_OK  = 8'h05;

	// Command indexes
	localparam logic [7:0] CMD_GO_IDLE  = 8'd0;
	localparam logic [7:0] CMD_SEND_OP  = 8'd1;
	localparam logic [7:0] CMD_IF_COND  = 8'd8;
	localparam logic [7:0] CMD_BLOCKLEN = 8'd16;
	localparam logic [7:0] CMD_READ     = 8'd17;
	localparam logic [7:0] CMD_WRITE    = 8'd24;
	localparam logic [7:0] CMD_APP_OP   = 8'd41;
	localparam logic [7:0] CMD_APP      = 8'd55;

	typedef enum logic [2:0] {
		FP_IDLE, FP_ARG1, FP_ARG2, FP_ARG3, FP_ARG4, FP_CRC, FP_WDATA
	} frame_t;

	typedef enum logic [3:0] {
		RP_START, RP_CMD0, RP_CMD1, RP_CMD8, RP_CMD41, RP_CMD16, RP_CMD55,
		RP_CMD17, RP_TOKEN, RP_READING, RP_CMD24, RP_WRESULT
	} resp_t;

	typedef enum logic [1:0] {
		ST_CLEAR, ST_IDLE, ST_MEM, ST_FLUSH
	} ctrl_state_t;

	typedef enum logic [1:0] {
		OSEL_NONE, OSEL_RESP, OSEL_MEM, OSEL_FLUSH
	} out_sel_t;

	typedef struct packed {
		logic     take;
		logic     clear_run;
		logic     flush_run;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic rd_mem;
		logic rd_flush;
		logic flush_done;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/sdr_in_if.sv =====
// Host item channel of the SD card SPI responder.
// Carries valid, ready and the item payload; no dependencies.
`default_nettype none

interface sdr_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] data_byte;

	modport source (output valid, output command, output data_byte, input ready);
	modport sink (input valid, input command, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/sdr_out_if.sv =====
// Result channel of the SD card SPI responder.
// Carries valid, ready and the returned byte; no dependencies.
`default_nettype none

interface sdr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_byte;

	modport source (output valid, output read_byte, input ready);
	modport sink (input valid, input read_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/sdr_ctrl.sv =====
// Controller state machine of the SD card SPI responder.
// Depends on sdr_pkg for state, command and status types.
`default_nettype none

module sdr_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire logic         in_command,
	output logic              in_ready,
	input  wire logic         out_ready,
	output logic              out_valid,
	input  wire sdr_pkg::sts_t sts,
	output sdr_pkg::cmd_t     cmd
);
	import sdr_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        take;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign take      = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (take && in_command) begin
					if (sts.rd_mem) state_d = ST_MEM;
					else if (sts.rd_flush) state_d = ST_FLUSH;
				end
			end
			ST_MEM: state_d = ST_IDLE;
			ST_FLUSH: begin
				if (sts.flush_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd = '0;
		cmd.out_sel = OSEL_NONE;
		case (state_q)
			ST_CLEAR: cmd.clear_run = 1'b1;
			ST_IDLE: begin
				cmd.take = take;
				if (take && in_command && !sts.rd_mem && !sts.rd_flush)
					cmd.out_sel = OSEL_RESP;
			end
			ST_MEM: cmd.out_sel = OSEL_MEM;
			ST_FLUSH: begin
				cmd.flush_run = 1'b1;
				if (sts.flush_done) cmd.out_sel = OSEL_FLUSH;
			end
			default: cmd = '0;
		endcase
	end

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_sel != OSEL_NONE) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sdr_datapath.sv =====
// Datapath of the SD card SPI responder: frame parser, registers,
// write buffer and byte store. Depends on sdr_pkg.
`default_nettype none

module sdr_datapath #(
	parameter int STORE_ADDR_BITS = sdr_pkg::STORE_ADDR_BITS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sdr_pkg::cmd_t cmd,
	output sdr_pkg::sts_t      sts,
	input  wire logic          in_command,
	input  wire logic [7:0]    in_data,
	output logic [7:0]         read_byte
);
	import sdr_pkg::*;

	localparam int N = STORE_ADDR_BITS;

	frame_t      frame_q;
	resp_t       resp_q;
	logic [7:0]  cmd_idx_q;
	logic [31:0] arg_q;
	logic [31:0] rd_base_q, wr_base_q;
	logic [9:0]  rd_off_q, wr_off_q, hwm_q;
	logic [9:0]  flush_cnt_q;
	logic [N:0]  clr_cnt_q;

	logic        flush_v_s1, keep_s1;
	logic [9:0]  flush_idx_s1;
	logic [7:0]  buf_rd_s1;
	logic [7:0]  store_rd_q;
	logic [7:0]  out_q;
	logic [7:0]  resp_byte;

	logic [7:0]  wbuf_mem [WBUF_BYTES];
	logic [7:0]  store_mem [0:(64'd1 << N) - 1];

	logic        is_send, is_read, buf_wr;
	logic [9:0]  wr_off_inc;
	logic [31:0] arg_full;
	logic [N-1:0] rd_addr;
	logic        store_we;
	logic [N-1:0] store_waddr;
	logic [7:0]  store_wdata;
	logic        flush_issue;

	assign is_send    = cmd.take && !in_command;
	assign is_read    = cmd.take && in_command;
	assign wr_off_inc = wr_off_q + 10'd1;
	assign arg_full   = {arg_q[31:8], in_data};
	assign buf_wr     = is_send && (frame_q == FP_WDATA) && (wr_off_q < 10'(WBUF_BYTES));
	assign rd_addr    = rd_base_q[N-1:0] + N'(rd_off_q);
	assign flush_issue = cmd.flush_run && (flush_cnt_q < 10'(BLOCK_BYTES));

	assign sts.clear_done = clr_cnt_q[N];
	assign sts.rd_mem     = (resp_q == RP_READING) && (rd_off_q < 10'(BLOCK_BYTES));
	assign sts.rd_flush   = (resp_q == RP_WRESULT);
	assign sts.flush_done = (flush_cnt_q == 10'(BLOCK_BYTES)) && !flush_v_s1;
	assign read_byte      = out_q;

	// Immediate response by phase
	always_comb begin
		case (resp_q)
			RP_CMD0:  resp_byte = RESP_IDLE;
			RP_CMD41: resp_byte = RESP_APP;
			RP_CMD55: resp_byte = RESP_APP;
			RP_TOKEN: resp_byte = DATA_TOKEN;
			default:  resp_byte = RESP_OK;
		endcase
	end

	// Frame parser, command decode and response phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q   <= FP_IDLE;
			resp_q    <= RP_START;
			cmd_idx_q <= '0;
			arg_q     <= '0;
			rd_base_q <= '0;
			wr_base_q <= '0;
			rd_off_q  <= '0;
			wr_off_q  <= '0;
			hwm_q     <= '0;
		end else if (is_send) begin
			case (frame_q)
				FP_IDLE: begin
					if (in_data == DATA_TOKEN) begin
						frame_q <= FP_WDATA;
					end else if ((in_data & START_BIT) != 8'h00) begin
						cmd_idx_q <= in_data & START_CLR;
						frame_q   <= FP_ARG1;
					end
				end
				FP_ARG1: begin
					arg_q   <= {in_data, 24'h0};
					frame_q <= FP_ARG2;
				end
				FP_ARG2: begin
					arg_q[23:16] <= in_data;
					frame_q      <= FP_ARG3;
				end
				FP_ARG3: begin
					arg_q[15:8] <= in_data;
					frame_q     <= FP_ARG4;
				end
				FP_ARG4: begin
					arg_q   <= arg_full;
					frame_q <= FP_CRC;
					case (cmd_idx_q)
						CMD_GO_IDLE:  resp_q <= RP_CMD0;
						CMD_SEND_OP:  resp_q <= RP_CMD1;
						CMD_IF_COND:  resp_q <= RP_CMD8;
						CMD_APP_OP:   resp_q <= RP_CMD41;
						CMD_APP:      resp_q <= RP_CMD55;
						CMD_BLOCKLEN: resp_q <= RP_CMD16;
						CMD_READ: begin
							resp_q    <= RP_CMD17;
							rd_base_q <= arg_full;
							rd_off_q  <= '0;
						end
						CMD_WRITE: begin
							resp_q    <= RP_CMD24;
							wr_base_q <= arg_full;
							wr_off_q  <= '0;
						end
						default: resp_q <= resp_q;
					endcase
				end
				FP_CRC: frame_q <= FP_IDLE;
				FP_WDATA: begin
					if (buf_wr) begin
						wr_off_q <= wr_off_inc;
						if (wr_off_inc > hwm_q) hwm_q <= wr_off_inc;
						if (wr_off_inc >= 10'(WBUF_BYTES)) frame_q <= FP_IDLE;
					end else begin
						frame_q <= FP_IDLE;
					end
				end
				default: frame_q <= FP_IDLE;
			endcase
		end else if (is_read) begin
			case (resp_q)
				RP_CMD17: resp_q <= RP_TOKEN;
				RP_TOKEN: resp_q <= RP_READING;
				RP_READING: begin
					if (sts.rd_mem) rd_off_q <= rd_off_q + 10'd1;
				end
				RP_CMD24: resp_q <= RP_WRESULT;
				default: resp_q <= resp_q;
			endcase
		end
	end

	// Clear sweep and flush counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			flush_cnt_q <= 10'(BLOCK_BYTES);
			flush_v_s1  <= 1'b0;
		end else begin
			if (cmd.clear_run && !clr_cnt_q[N]) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (is_read && sts.rd_flush) flush_cnt_q <= '0;
			else if (flush_issue) flush_cnt_q <= flush_cnt_q + 10'd1;
			flush_v_s1 <= flush_issue;
		end
	end

	// Flush stage one: buffer read; entries past the fill mark read zero
	always_ff @(posedge clk) begin
		flush_idx_s1 <= flush_cnt_q;
		keep_s1      <= flush_cnt_q < hwm_q;
		buf_rd_s1    <= wbuf_mem[flush_cnt_q];
	end

	// Write buffer fill
	always_ff @(posedge clk) begin
		if (buf_wr) wbuf_mem[wr_off_q] <= in_data;
	end

	// Store write: clear sweep, else flush stage two
	always_comb begin
		store_we    = 1'b0;
		store_waddr = clr_cnt_q[N-1:0];
		store_wdata = RESP_OK;
		if (cmd.clear_run && !clr_cnt_q[N]) begin
			store_we = 1'b1;
		end else if (flush_v_s1) begin
			store_we    = 1'b1;
			store_waddr = wr_base_q[N-1:0] + N'(flush_idx_s1);
			store_wdata = keep_s1 ? buf_rd_s1 : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) store_mem[store_waddr] <= store_wdata;
		store_rd_q <= store_mem[rd_addr];
	end

	// Result register
	always_ff @(posedge clk) begin
		case (cmd.out_sel)
			OSEL_RESP:  out_q <= resp_byte;
			OSEL_MEM:   out_q <= store_rd_q;
			OSEL_FLUSH: out_q <= RESP_WR_OK;
			default:    out_q <= out_q;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/sd_card_spi_responder.sv =====
// SD card SPI responder: one item per host byte, sent or read. After reset the
// block sweeps its byte store to zero, one byte per cycle, before taking items.
// A read of block data goes through the registered store read port; a read in
// the write-result phase copies 512 buffered bytes into the store through the
// single store write port.
`default_nettype none

`include "sd_card_spi_responder_assert.svh"

module sd_card_spi_responder #(
	parameter int STORE_ADDR_BITS = sdr_pkg::STORE_ADDR_BITS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sdr_in_if.sink     host_in,
	sdr_out_if.source  host_out
);
	import sdr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sdr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (host_in.valid),
		.in_command (host_in.command),
		.in_ready   (host_in.ready),
		.out_ready  (host_out.ready),
		.out_valid  (host_out.valid),
		.sts        (sts),
		.cmd        (cmd)
	);

	sdr_datapath #(
		.STORE_ADDR_BITS (STORE_ADDR_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_command (host_in.command),
		.in_data    (host_in.data_byte),
		.read_byte  (host_out.read_byte)
	);

	// Checks
	`SDR_ASSERT_SAME(a_no_take_in_clear, host_in.ready, sts.clear_done, "item taken during clear")
	`SDR_ASSERT_SAME(a_flush_done, cmd.out_sel == OSEL_FLUSH, sts.flush_done, "early flush result")
	`SDR_ASSERT_NEXT(a_load_valid, cmd.out_sel != OSEL_NONE, host_out.valid, "result lost")

endmodule

`default_nettype wire
